// ===== rtl/core/gwap_pkg.sv =====
// Package: shared constants, types and helpers of the grid window A* planner.
package gwap_pkg;

  // Sizing of the window, open list, path buffer and heuristic precision
  localparam int WINDOW_MAX     = 50;
  localparam int OPEN_DEPTH     = 2500;
  localparam int PATH_MAX       = 64;
  localparam int HEUR_FRAC_BITS = 8;

  localparam int CELLS   = WINDOW_MAX * WINDOW_MAX;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int CRD_W   = $clog2(WINDOW_MAX);
  localparam int RAD_W   = 5;
  localparam int SIDE_W  = RAD_W + 1;
  localparam int THR_W   = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int OCC_W   = 8;
  localparam int GOAL_W  = 12;
  localparam int STEP_W  = 6;

  localparam int OPEN_AW = $clog2(OPEN_DEPTH);
  localparam int OCNT_W  = $clog2(OPEN_DEPTH + 1);
  localparam int PATH_AW = $clog2(PATH_MAX);
  localparam int PLEN_W  = $clog2(PATH_MAX + 1);

  localparam int COST_W = 12;
  localparam int DIR_W  = 3;
  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [DIR_W-1:0]  DIR_NONE = 3'd4;
  localparam int NODE_W = 1 + DIR_W + COST_W;

  // Heuristic square root widths
  localparam int D2_W     = 2 * CRD_W + 1;
  localparam int V_RAW    = D2_W + 2 * HEUR_FRAC_BITS;
  localparam int V_W      = V_RAW + (V_RAW % 2);
  localparam int H_W      = V_W / 2;
  localparam int SQ_STEPS = V_W / 2;
  localparam int SQC_W    = $clog2(SQ_STEPS + 1);

  localparam int F_W     = COST_W + HEUR_FRAC_BITS + 1;
  localparam int OPEN_W  = F_W + 2 * CRD_W;
  localparam int PBUF_W  = 2 * CRD_W;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'd1;

  localparam logic [RAD_W-1:0] RADIUS_RST = 5'd10;
  localparam logic [THR_W-1:0] THRESH_RST = 8'd165;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_IDLE, OP_CLR, OP_HSTART, OP_HWAIT, OP_POP, OP_SCAN, OP_MOVE_RD,
    OP_MOVE_WR, OP_NODE_CHK, OP_NB, OP_NB_CHK, OP_NB_NEXT, OP_TB_INIT,
    OP_TB_CHK, OP_TB_DIR, OP_TB_END, OP_EMIT_RD, OP_EMIT_WR, OP_FAIL
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic plan_go;
    logic clr_last;
    logic h_done;
    logic open_empty;
    logic scan_done;
    logic node_closed;
    logic at_goal;
    logic nb_out;
    logic nb_reject;
    logic m_last;
    logic tb_stop;
    logic tb_dir_end;
    logic out_free;
    logic emit_last;
  } status_t;

  // Neighbor offsets: right, left, down, up
  function automatic logic signed [1:0] move_dx(input logic [1:0] m);
    logic signed [1:0] d;
    unique case (m)
      2'd0: d = 2'sd1;
      2'd1: d = -2'sd1;
      2'd2: d = 2'sd0;
      2'd3: d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] move_dy(input logic [1:0] m);
    logic signed [1:0] d;
    unique case (m)
      2'd0: d = 2'sd0;
      2'd1: d = 2'sd0;
      2'd2: d = 2'sd1;
      2'd3: d = -2'sd1;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/gwap_ram.sv =====
// Generic simple dual-port RAM with registered read.
module gwap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/gwap_hsqrt.sv =====
// Bit-serial rounded square root of the scaled squared goal distance.
module gwap_hsqrt
  import gwap_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CRD_W-1:0] x_i,
  input  logic [CRD_W-1:0] y_i,
  input  logic [CRD_W-1:0] gx_i,
  input  logic [CRD_W-1:0] gy_i,
  output logic             done_o,
  output logic [H_W-1:0]   h_o
);

  logic signed [CRD_W:0] dx, dy;
  logic [CRD_W-1:0]      adx, ady;
  logic [2*CRD_W-1:0]    dxx, dyy;
  logic [D2_W-1:0]       d2;
  logic [V_W-1:0]        v_q, r_q, bit_q;
  logic [V_W:0]          rb;
  logic                  busy_q, rnd_q, done_q;
  logic [SQC_W-1:0]      cnt_q;
  logic [H_W-1:0]        h_q;

  // squared distance, magnitudes first so the products stay unsigned
  assign dx  = $signed({1'b0, gx_i}) - $signed({1'b0, x_i});
  assign dy  = $signed({1'b0, gy_i}) - $signed({1'b0, y_i});
  assign adx = dx[CRD_W] ? CRD_W'(-dx) : CRD_W'(dx);
  assign ady = dy[CRD_W] ? CRD_W'(-dy) : CRD_W'(dy);
  assign dxx = {{CRD_W{1'b0}}, adx} * {{CRD_W{1'b0}}, adx};
  assign dyy = {{CRD_W{1'b0}}, ady} * {{CRD_W{1'b0}}, ady};
  assign d2  = {1'b0, dxx} + {1'b0, dyy};

  assign rb = {1'b0, r_q} + {1'b0, bit_q};

  // one restoring step per cycle, then a rounding step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SQC_W'(SQ_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == SQC_W'(1)) begin
          busy_q <= 1'b0;
          rnd_q  <= 1'b1;
        end
      end else if (rnd_q) begin
        rnd_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= V_W'({d2, {(2 * HEUR_FRAC_BITS){1'b0}}});
      r_q   <= '0;
      bit_q <= V_W'(1) << (V_W - 2);
    end else if (busy_q) begin
      if ({1'b0, v_q} >= rb) begin
        v_q <= v_q - rb[V_W-1:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end else if (rnd_q) begin
      h_q <= (v_q > r_q) ? H_W'(r_q + 1'b1) : H_W'(r_q);
    end
  end

  assign done_o = done_q;
  assign h_o    = h_q;

endmodule

// ===== rtl/core/gwap_dp.sv =====
// Datapath: window memories, open list, search registers and stream ports.
module gwap_dp
  import gwap_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast,
  input  cmd_t                   cmd_i,
  output status_t                st_o
);

  // configuration and load state
  logic [RAD_W-1:0]   radius_q;
  logic [THR_W-1:0]   thresh_q;
  logic [CELL_AW-1:0] load_idx_q;
  logic [SIDE_W-1:0]  side;
  logic [CELL_AW-1:0] ncell, side_ext;
  logic               too_big;

  // plan state
  logic [CRD_W-1:0]   gx_q, gy_q, cur_x_q, cur_y_q, pend_x_q, pend_y_q, p_x_q, p_y_q;
  logic [CELL_AW-1:0] clr_q;
  logic [OCNT_W-1:0]  scan_q, cnt_q;
  logic               rv_q;
  logic [OPEN_AW-1:0] ridx_q, best_idx_q;
  logic [F_W-1:0]     best_f_q;
  logic [COST_W-1:0]  cur_g_q, pend_g_q;
  logic [1:0]         m_q;
  logic [PLEN_W-1:0]  len_q;
  logic [PATH_AW-1:0] k_q;

  // output register
  logic               ovalid_q, ofound_q, olast_q;
  logic [STEP_W-1:0]  odx_q, ody_q;

  op_e op;
  assign op = cmd_i.op;

  assign side     = {radius_q, 1'b1};
  assign side_ext = CELL_AW'(side);
  assign ncell    = side_ext * side_ext;
  assign too_big  = side > SIDE_W'(WINDOW_MAX);

  // input beat decode
  logic               out_free, acc, load_acc, plan_acc;
  logic [OCC_W-1:0]   occ;
  logic               cell_in;
  logic signed [GOAL_W-1:0] gdx, gdy;
  logic signed [GOAL_W:0]   gxs, gys, smax;
  logic [CRD_W-1:0]   gx_c, gy_c, rad_c;

  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (op == OP_IDLE) && out_free;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign load_acc      = acc && !s_axis_tuser && !too_big;
  assign plan_acc      = acc && s_axis_tuser;
  assign occ     = s_axis_tdata[OCC_W-1:0];
  assign cell_in = s_axis_tdata[OCC_W];
  assign gdx     = s_axis_tdata[OCC_W+1 +: GOAL_W];
  assign gdy     = s_axis_tdata[OCC_W+1+GOAL_W +: GOAL_W];
  assign rad_c   = CRD_W'(radius_q);

  // clamp the goal into the window
  assign smax = $signed({{(GOAL_W+1-SIDE_W){1'b0}}, side - 1'b1});
  assign gxs  = $signed({gdx[GOAL_W-1], gdx}) + $signed({{(GOAL_W+1-RAD_W){1'b0}}, radius_q});
  assign gys  = $signed({gdy[GOAL_W-1], gdy}) + $signed({{(GOAL_W+1-RAD_W){1'b0}}, radius_q});
  assign gx_c = gxs[GOAL_W] ? '0 : ((gxs > smax) ? CRD_W'(smax) : CRD_W'(gxs));
  assign gy_c = gys[GOAL_W] ? '0 : ((gys > smax) ? CRD_W'(smax) : CRD_W'(gys));

  // raster write index of a loaded cell
  logic [CELL_AW-1:0] load_wr;
  logic [CELL_AW:0]   load_nxt;
  assign load_wr  = (load_idx_q >= ncell) ? '0 : load_idx_q;
  assign load_nxt = {1'b0, load_wr} + 1'b1;

  // neighbor coordinates
  logic signed [CRD_W+1:0] nx, ny;
  logic                    nb_out;
  assign nx = $signed({2'b00, cur_x_q}) + move_dx(m_q);
  assign ny = $signed({2'b00, cur_y_q}) + move_dy(m_q);
  assign nb_out = nx[CRD_W+1] || ny[CRD_W+1] ||
                  (nx >= $signed({2'b00, side})) || (ny >= $signed({2'b00, side}));

  // shared cell address
  logic [CRD_W-1:0]   a_x, a_y;
  logic [CELL_AW-1:0] cell_a;
  always_comb begin
    case (op)
      OP_HSTART:           begin a_x = rad_c;          a_y = rad_c;          end
      OP_NB, OP_NB_CHK:    begin a_x = CRD_W'(nx);     a_y = CRD_W'(ny);     end
      OP_TB_CHK:           begin a_x = p_x_q;          a_y = p_y_q;          end
      default:             begin a_x = cur_x_q;        a_y = cur_y_q;        end
    endcase
  end
  assign cell_a = CELL_AW'(a_y) * side_ext + CELL_AW'(a_x);

  // memories
  logic [NODE_W-1:0]  node_wdata, node_rdata;
  logic               node_we, node_re;
  logic [CELL_AW-1:0] node_waddr;
  logic               blk_rdata;
  logic [OPEN_W-1:0]  open_wdata, open_rdata;
  logic               open_we, open_re;
  logic [OPEN_AW-1:0] open_waddr, open_raddr;
  logic [PBUF_W-1:0]  pb_wdata, pb_rdata;
  logic               pb_we;

  logic               n_closed;
  logic [DIR_W-1:0]   n_dir;
  logic [COST_W-1:0]  n_cost, ng;
  logic               nb_reject, push, h_done, tb_stop, tb_dir_end, sq_start;
  logic [H_W-1:0]     h;
  logic [F_W-1:0]     f_rd, f_push;
  logic               issue;

  assign n_closed  = node_rdata[NODE_W-1];
  assign n_dir     = node_rdata[COST_W +: DIR_W];
  assign n_cost    = node_rdata[COST_W-1:0];
  assign ng        = cur_g_q + 1'b1;
  assign nb_reject = n_closed || blk_rdata || !(ng < n_cost);
  assign push      = (op == OP_HWAIT) && h_done && (cnt_q < OCNT_W'(OPEN_DEPTH));
  assign f_push    = F_W'({pend_g_q, {HEUR_FRAC_BITS{1'b0}}}) + F_W'(h);
  assign f_rd      = open_rdata[OPEN_W-1 -: F_W];
  assign issue     = scan_q < cnt_q;
  assign tb_stop   = ((p_x_q == rad_c) && (p_y_q == rad_c)) || (len_q == PLEN_W'(PATH_MAX));
  assign sq_start  = (op == OP_HSTART) || ((op == OP_NB_CHK) && !nb_reject);

  // traceback predecessor
  logic [1:0]              tdir;
  logic signed [CRD_W+1:0] px, py;
  assign tdir = n_dir[1:0];
  assign px = $signed({2'b00, p_x_q}) - move_dx(tdir);
  assign py = $signed({2'b00, p_y_q}) - move_dy(tdir);
  assign tb_dir_end = (n_dir >= DIR_NONE) || px[CRD_W+1] || py[CRD_W+1] ||
                      (px >= $signed({2'b00, side})) || (py >= $signed({2'b00, side}));

  // node word: closed, direction, cost
  always_comb begin
    node_we    = 1'b0;
    node_waddr = cell_a;
    node_wdata = {1'b0, DIR_NONE, COST_MAX};
    case (op)
      OP_CLR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
      end
      OP_HSTART: begin
        node_we    = 1'b1;
        node_wdata = {1'b0, DIR_NONE, {COST_W{1'b0}}};
      end
      OP_NODE_CHK: begin
        node_we    = !n_closed;
        node_wdata = {1'b1, n_dir, n_cost};
      end
      OP_NB_CHK: begin
        node_we    = !nb_reject;
        node_wdata = {1'b0, DIR_W'(m_q), ng};
      end
      default: ;
    endcase
  end
  assign node_re = (op == OP_MOVE_WR) || ((op == OP_NB) && !nb_out) ||
                   ((op == OP_TB_CHK) && !tb_stop);

  gwap_ram #(.WIDTH(NODE_W), .DEPTH(CELLS)) u_node (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .re_i(node_re), .raddr_i(cell_a), .rdata_o(node_rdata)
  );

  gwap_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk (
    .clk_i, .we_i(load_acc), .waddr_i(load_wr),
    .wdata_i(!cell_in || (occ > thresh_q)),
    .re_i((op == OP_NB) && !nb_out), .raddr_i(cell_a), .rdata_o(blk_rdata)
  );

  // open list entries: f, row, column
  assign open_we    = push || (op == OP_MOVE_WR);
  assign open_waddr = (op == OP_MOVE_WR) ? best_idx_q : OPEN_AW'(cnt_q);
  assign open_wdata = (op == OP_MOVE_WR) ? open_rdata : {f_push, pend_y_q, pend_x_q};
  assign open_re    = ((op == OP_SCAN) && issue) || (op == OP_MOVE_RD);
  assign open_raddr = (op == OP_MOVE_RD) ? OPEN_AW'(cnt_q - 1'b1) : OPEN_AW'(scan_q);

  gwap_ram #(.WIDTH(OPEN_W), .DEPTH(OPEN_DEPTH)) u_open (
    .clk_i, .we_i(open_we), .waddr_i(open_waddr), .wdata_i(open_wdata),
    .re_i(open_re), .raddr_i(open_raddr), .rdata_o(open_rdata)
  );

  // path buffer, goal side first
  assign pb_we    = ((op == OP_TB_CHK) && !tb_stop) ||
                    ((op == OP_TB_END) && (len_q < PLEN_W'(PATH_MAX)));
  assign pb_wdata = (op == OP_TB_END) ? {rad_c, rad_c} : {p_y_q, p_x_q};

  gwap_ram #(.WIDTH(PBUF_W), .DEPTH(PATH_MAX)) u_path (
    .clk_i, .we_i(pb_we), .waddr_i(PATH_AW'(len_q)), .wdata_i(pb_wdata),
    .re_i(op == OP_EMIT_RD), .raddr_i(k_q), .rdata_o(pb_rdata)
  );

  gwap_hsqrt u_hsqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .x_i(a_x), .y_i(a_y),
    .gx_i(gx_q), .gy_i(gy_q), .done_o(h_done), .h_o(h)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RADIUS_RST;
      thresh_q   <= THRESH_RST;
      load_idx_q <= '0;
      cnt_q      <= '0;
      rv_q       <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_RADIUS: radius_q <= cfg_wdata_i[RAD_W-1:0];
          CFG_THRESH: thresh_q <= cfg_wdata_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (load_acc) begin
        load_idx_q <= (load_nxt >= {1'b0, ncell}) ? '0 : CELL_AW'(load_nxt);
      end else if (plan_acc) begin
        load_idx_q <= '0;
      end
      if (op == OP_HSTART) begin
        cnt_q <= '0;
      end else if (push) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (op == OP_MOVE_RD) begin
        cnt_q <= cnt_q - 1'b1;
      end
      rv_q <= (op == OP_SCAN) && issue;
      // result beat register
      if ((plan_acc && too_big) || ((op == OP_FAIL) && out_free) ||
          ((op == OP_EMIT_WR) && out_free)) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // search payload registers
  always_ff @(posedge clk_i) begin
    if (plan_acc) begin
      gx_q  <= gx_c;
      gy_q  <= gy_c;
      clr_q <= '0;
    end
    if (op == OP_CLR) begin
      clr_q <= clr_q + 1'b1;
    end
    if (sq_start) begin
      pend_x_q <= a_x;
      pend_y_q <= a_y;
      pend_g_q <= (op == OP_HSTART) ? '0 : ng;
    end
    if (op == OP_POP) begin
      scan_q <= '0;
    end else if ((op == OP_SCAN) && issue) begin
      scan_q <= scan_q + 1'b1;
    end
    ridx_q <= OPEN_AW'(scan_q);
    // first strictly smallest f wins
    if ((op == OP_SCAN) && rv_q && ((ridx_q == '0) || (f_rd < best_f_q))) begin
      best_f_q   <= f_rd;
      best_idx_q <= ridx_q;
      cur_x_q    <= open_rdata[CRD_W-1:0];
      cur_y_q    <= open_rdata[CRD_W +: CRD_W];
    end
    if (op == OP_NODE_CHK) begin
      cur_g_q <= n_cost;
      m_q     <= '0;
    end else if (op == OP_NB_NEXT) begin
      m_q <= m_q + 1'b1;
    end
    if (op == OP_TB_INIT) begin
      p_x_q <= gx_q;
      p_y_q <= gy_q;
      len_q <= '0;
    end else if ((op == OP_TB_CHK) && !tb_stop) begin
      len_q <= len_q + 1'b1;
    end else if ((op == OP_TB_DIR) && !tb_dir_end) begin
      p_x_q <= CRD_W'(px);
      p_y_q <= CRD_W'(py);
    end
    if (op == OP_TB_END) begin
      k_q <= (len_q < PLEN_W'(PATH_MAX)) ? PATH_AW'(len_q) : PATH_AW'(PATH_MAX - 1);
    end else if ((op == OP_EMIT_WR) && out_free && (k_q != '0)) begin
      k_q <= k_q - 1'b1;
    end
    // result beat payload
    if ((plan_acc && too_big) || ((op == OP_FAIL) && out_free)) begin
      odx_q    <= '0;
      ody_q    <= '0;
      ofound_q <= 1'b0;
      olast_q  <= 1'b1;
    end else if ((op == OP_EMIT_WR) && out_free) begin
      odx_q    <= STEP_W'(pb_rdata[CRD_W-1:0]) - STEP_W'(radius_q);
      ody_q    <= STEP_W'(pb_rdata[CRD_W +: CRD_W]) - STEP_W'(radius_q);
      ofound_q <= 1'b1;
      olast_q  <= (k_q == '0);
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({ody_q, odx_q});
  assign m_axis_tuser  = ofound_q;
  assign m_axis_tlast  = olast_q;

  // status toward the controller
  assign st_o.plan_go     = plan_acc && !too_big;
  assign st_o.clr_last    = (clr_q == ncell - 1'b1);
  assign st_o.h_done      = h_done;
  assign st_o.open_empty  = (cnt_q == '0);
  assign st_o.scan_done   = !issue && !rv_q;
  assign st_o.node_closed = n_closed;
  assign st_o.at_goal     = (cur_x_q == gx_q) && (cur_y_q == gy_q);
  assign st_o.nb_out      = nb_out;
  assign st_o.nb_reject   = nb_reject;
  assign st_o.m_last      = (m_q == 2'd3);
  assign st_o.tb_stop     = tb_stop;
  assign st_o.tb_dir_end  = tb_dir_end;
  assign st_o.out_free    = out_free;
  assign st_o.emit_last   = (k_q == '0);

endmodule

// ===== rtl/core/gwap_ctrl.sv =====
// Controller: sequences the plan through clear, search, traceback and emit.
module gwap_ctrl
  import gwap_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CLR     = 5'd1;
  localparam logic [4:0] S_HSTART  = 5'd2;
  localparam logic [4:0] S_HWAIT_S = 5'd3;
  localparam logic [4:0] S_POP     = 5'd4;
  localparam logic [4:0] S_SCAN    = 5'd5;
  localparam logic [4:0] S_MOVE_RD = 5'd6;
  localparam logic [4:0] S_MOVE_WR = 5'd7;
  localparam logic [4:0] S_NODE    = 5'd8;
  localparam logic [4:0] S_NB      = 5'd9;
  localparam logic [4:0] S_NB_CHK  = 5'd10;
  localparam logic [4:0] S_HWAIT_N = 5'd11;
  localparam logic [4:0] S_NB_NEXT = 5'd12;
  localparam logic [4:0] S_TB      = 5'd13;
  localparam logic [4:0] S_TB_CHK  = 5'd14;
  localparam logic [4:0] S_TB_DIR  = 5'd15;
  localparam logic [4:0] S_TB_END  = 5'd16;
  localparam logic [4:0] S_EMIT_RD = 5'd17;
  localparam logic [4:0] S_EMIT_WR = 5'd18;
  localparam logic [4:0] S_FAIL    = 5'd19;

  logic [4:0] state_q, state_d;
  op_e        op;

  // next state and operation
  always_comb begin
    state_d = state_q;
    op      = OP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        op = OP_IDLE;
        if (st_i.plan_go) state_d = S_CLR;
      end
      S_CLR: begin
        op = OP_CLR;
        if (st_i.clr_last) state_d = S_HSTART;
      end
      S_HSTART: begin
        op      = OP_HSTART;
        state_d = S_HWAIT_S;
      end
      S_HWAIT_S: begin
        op = OP_HWAIT;
        if (st_i.h_done) state_d = S_POP;
      end
      S_POP: begin
        op      = OP_POP;
        state_d = st_i.open_empty ? S_FAIL : S_SCAN;
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (st_i.scan_done) state_d = S_MOVE_RD;
      end
      S_MOVE_RD: begin
        op      = OP_MOVE_RD;
        state_d = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        op      = OP_MOVE_WR;
        state_d = S_NODE;
      end
      S_NODE: begin
        op = OP_NODE_CHK;
        if (st_i.node_closed) state_d = S_POP;
        else if (st_i.at_goal) state_d = S_TB;
        else                   state_d = S_NB;
      end
      S_NB: begin
        op      = OP_NB;
        state_d = st_i.nb_out ? S_NB_NEXT : S_NB_CHK;
      end
      S_NB_CHK: begin
        op      = OP_NB_CHK;
        state_d = st_i.nb_reject ? S_NB_NEXT : S_HWAIT_N;
      end
      S_HWAIT_N: begin
        op = OP_HWAIT;
        if (st_i.h_done) state_d = S_NB_NEXT;
      end
      S_NB_NEXT: begin
        op      = OP_NB_NEXT;
        state_d = st_i.m_last ? S_POP : S_NB;
      end
      S_TB: begin
        op      = OP_TB_INIT;
        state_d = S_TB_CHK;
      end
      S_TB_CHK: begin
        op      = OP_TB_CHK;
        state_d = st_i.tb_stop ? S_TB_END : S_TB_DIR;
      end
      S_TB_DIR: begin
        op      = OP_TB_DIR;
        state_d = st_i.tb_dir_end ? S_TB_END : S_TB_CHK;
      end
      S_TB_END: begin
        op      = OP_TB_END;
        state_d = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        op      = OP_EMIT_RD;
        state_d = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        op = OP_EMIT_WR;
        if (st_i.out_free) state_d = st_i.emit_last ? S_IDLE : S_EMIT_RD;
      end
      S_FAIL: begin
        op = OP_FAIL;
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: begin
        op      = OP_IDLE;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.op = op;

endmodule

// ===== rtl/core/grid_window_astar_planner_core.sv =====
// Top level of the grid window A* planner: controller, datapath and checks.
//
// Load beats (tuser 0) write one window cell each and are taken one per
// cycle while no path beat waits at the output. A plan beat (tuser 1) holds
// off the input for the whole search: first a clearing pass over the S*S
// cells of the node memory (S = 2*radius+1), then a start step and the
// bit-serial square root for the start heuristic. Each expansion pops the
// best entry by a linear scan of the open list with one open-list memory
// read per cycle, removes it and checks the node; each of the four
// neighbors is then skipped when outside the window or rejected, and waits
// on the square root when accepted. Traceback walks the stored directions
// back from the goal, and the path beats leave as the receiver takes them.
// A plan with a window wider than the maximum returns its single no-path
// beat at once.
module grid_window_astar_planner_core
  import gwap_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] cell_occupancy, [8] cell_inside, [20:9] goal_dx, [32:21] goal_dy
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] command
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [5:0] step_dx, [11:6] step_dy
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] found
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  cmd_t    cmd;
  status_t st;

  gwap_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cmd_i(cmd), .st_o(st)
  );

  gwap_ctrl u_ctrl (
    .clk_i, .rst_ni, .st_i(st), .cmd_o(cmd)
  );

  // a no-path beat is always the only beat of its plan
  a_nopath_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("no-path beat without last");

  // the square root only finishes while the controller waits on it
  a_hdone_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.h_done |-> cmd.op == OP_HWAIT)
    else $error("heuristic finished outside a wait");

  // an entry is only removed from a non-empty open list
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_MOVE_RD |-> !st.open_empty)
    else $error("pop from empty open list");

  // a scan ends in the removal of the chosen entry
  a_scan_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_SCAN && st.scan_done |=> cmd.op == OP_MOVE_RD)
    else $error("scan not followed by removal");

endmodule
